@@ rtl/msrf_pkg.sv @@
// ----------------------------------------------------------------------------
// msrf_pkg
// shared types and constants of the measurement schedule record filter
// ----------------------------------------------------------------------------
package msrf_pkg;

    // list layout
    localparam logic [7:0]  SOH_BYTE     = 8'h01;
    localparam logic [4:0]  HEADER_BYTES = 5'd11;
    localparam logic [4:0]  RECORD_BYTES = 5'd20;
    localparam logic [4:0]  ID_BYTES_END = 5'd4;   // record id occupies bytes 0..3
    localparam logic [4:0]  START_END    = 5'd12;  // start time occupies bytes 4..11
    localparam logic [4:0]  HDR_LAST_ID  = 5'd8;   // last byte of the id fields
    localparam logic [15:0] MAX_RECORDS  = 16'd32;

    // result buffer
    localparam int RBUF_DEPTH = 4;
    localparam int RBUF_AW    = $clog2(RBUF_DEPTH);

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_RECORDS = 4'b0100,
        PH_ERROR   = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        EV_HEADER_OK = 3'd0,
        EV_KEPT      = 3'd1,
        EV_DONE_OK   = 3'd2,
        EV_DONE_NONE = 3'd3,
        EV_ERROR     = 3'd4
    } event_t;

    typedef struct packed {
        event_t      event_res;
        logic [15:0] setup_id;
        logic [15:0] user_id;
        logic [15:0] list_version;
        logic [15:0] company_id;
        logic [31:0] record_id;
        logic [63:0] window_start;
        logic [63:0] window_stop;
        logic [5:0]  kept_count;
        logic        last;
    } result_t;

    // up to two results per byte
    typedef struct packed {
        logic [1:0] n_results;
        result_t    res0;
        result_t    res1;
    } parse_out_t;

endpackage

@@ rtl/msrf_parse.sv @@
// ----------------------------------------------------------------------------
// msrf_parse
// byte parser: header and record assembly, window filter, result forming
// ----------------------------------------------------------------------------
module msrf_parse (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic [7:0]           data_byte,
    input  logic                 start_of_list,
    input  logic [63:0]          now_ms,
    output msrf_pkg::parse_out_t po
);
    import msrf_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [4:0]  byte_position_reg, byte_position_next;
    logic [63:0] header_fields_reg, header_fields_next;
    logic [15:0] records_remaining_reg, records_remaining_next;
    logic [5:0]  kept_total_reg, kept_total_next;
    logic [31:0] rec_id_reg, rec_id_next;
    logic [63:0] rec_start_reg, rec_start_next;
    logic [63:0] rec_stop_reg, rec_stop_next;

    logic        keep;
    logic [15:0] rem_dec;
    logic [5:0]  kept_inc;
    result_t     base;

    always_comb begin
        phase_next             = phase_reg;
        byte_position_next     = byte_position_reg;
        header_fields_next     = header_fields_reg;
        records_remaining_next = records_remaining_reg;
        kept_total_next        = kept_total_reg;
        rec_id_next            = rec_id_reg;
        rec_start_next         = rec_start_reg;
        rec_stop_next          = rec_stop_reg;

        keep     = 1'b0;
        rem_dec  = records_remaining_reg - 16'd1;
        kept_inc = kept_total_reg;

        // header values held for the list, no record
        base              = '0;
        base.event_res    = EV_ERROR;
        base.setup_id     = header_fields_reg[63:48];
        base.user_id      = header_fields_reg[47:32];
        base.list_version = header_fields_reg[31:16];
        base.company_id   = header_fields_reg[15:0];
        base.kept_count   = kept_total_reg;
        base.last         = 1'b1;

        po           = '0;
        po.res0      = base;
        po.res1      = base;

        if (step) begin
            if (start_of_list) begin
                header_fields_next     = '0;
                records_remaining_next = '0;
                kept_total_next        = '0;
                byte_position_next     = '0;
                if (data_byte != SOH_BYTE) begin
                    phase_next   = PH_ERROR;
                    po.n_results = 2'd1;
                    po.res0      = '0;
                    po.res0.event_res = EV_ERROR;
                    po.res0.last = 1'b1;
                end else begin
                    phase_next         = PH_HEADER;
                    byte_position_next = 5'd1;
                end
            end else begin
                case (phase_reg)
                    PH_HEADER: begin
                        if (byte_position_reg <= HDR_LAST_ID) begin
                            header_fields_next = {header_fields_reg[55:0], data_byte};
                        end else begin
                            records_remaining_next = {records_remaining_reg[7:0], data_byte};
                        end
                        if (byte_position_reg != HEADER_BYTES - 5'd1) begin
                            byte_position_next = byte_position_reg + 5'd1;
                        end else begin
                            byte_position_next = '0;
                            if (records_remaining_next > MAX_RECORDS) begin
                                phase_next   = PH_ERROR;
                                po.n_results = 2'd1;
                                po.res0.event_res = EV_ERROR;
                            end else if (records_remaining_next == 16'd0) begin
                                phase_next   = PH_IDLE;
                                po.n_results = 2'd2;
                                po.res0.event_res = EV_HEADER_OK;
                                po.res0.last = 1'b0;
                                po.res1.event_res = EV_DONE_NONE;
                            end else begin
                                phase_next   = PH_RECORDS;
                                po.n_results = 2'd1;
                                po.res0.event_res = EV_HEADER_OK;
                            end
                        end
                    end
                    PH_RECORDS: begin
                        if (byte_position_reg < ID_BYTES_END) begin
                            rec_id_next = {rec_id_reg[23:0], data_byte};
                        end else if (byte_position_reg < START_END) begin
                            rec_start_next = {rec_start_reg[55:0], data_byte};
                        end else begin
                            rec_stop_next = {rec_stop_reg[55:0], data_byte};
                        end
                        if (byte_position_reg != RECORD_BYTES - 5'd1) begin
                            byte_position_next = byte_position_reg + 5'd1;
                        end else begin
                            // last record byte: decide on the completed window
                            byte_position_next     = '0;
                            keep = (rec_start_reg < rec_stop_next) && (now_ms < rec_stop_next);
                            kept_inc               = kept_total_reg + {5'd0, keep};
                            kept_total_next        = kept_inc;
                            records_remaining_next = rem_dec;
                            po.res0.kept_count     = kept_inc;
                            po.res1.kept_count     = kept_inc;
                            po.res1.event_res      = (kept_inc != 6'd0) ? EV_DONE_OK
                                                                        : EV_DONE_NONE;
                            if (rem_dec == 16'd0) begin
                                phase_next = PH_IDLE;
                            end
                            if (keep) begin
                                po.res0.event_res    = EV_KEPT;
                                po.res0.record_id    = rec_id_reg;
                                po.res0.window_start = rec_start_reg;
                                po.res0.window_stop  = rec_stop_next;
                                if (rem_dec == 16'd0) begin
                                    po.n_results = 2'd2;
                                    po.res0.last = 1'b0;
                                end else begin
                                    po.n_results = 2'd1;
                                end
                            end else if (rem_dec == 16'd0) begin
                                po.n_results = 2'd1;
                                po.res0      = po.res1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg             <= PH_IDLE;
            byte_position_reg     <= '0;
            header_fields_reg     <= '0;
            records_remaining_reg <= '0;
            kept_total_reg        <= '0;
        end else begin
            phase_reg             <= phase_next;
            byte_position_reg     <= byte_position_next;
            header_fields_reg     <= header_fields_next;
            records_remaining_reg <= records_remaining_next;
            kept_total_reg        <= kept_total_next;
        end
    end

    always_ff @(posedge aclk) begin
        rec_id_reg    <= rec_id_next;
        rec_start_reg <= rec_start_next;
        rec_stop_reg  <= rec_stop_next;
    end

endmodule

@@ rtl/msrf_rbuf.sv @@
// ----------------------------------------------------------------------------
// msrf_rbuf
// small result queue taking up to two results per cycle, one out per cycle
// ----------------------------------------------------------------------------
module msrf_rbuf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  msrf_pkg::parse_out_t push,
    input  logic                 pop,
    output logic                 room2,
    output logic                 out_valid,
    output msrf_pkg::result_t    out_data
);
    import msrf_pkg::*;

    result_t              slot_reg [RBUF_DEPTH];
    logic [RBUF_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [RBUF_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [RBUF_AW:0]     count_reg, count_next;
    logic [RBUF_AW-1:0]   wr_ptr_p1;
    logic                 do_pop;

    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign room2     = (count_reg <= (RBUF_AW+1)'(RBUF_DEPTH - 2));
    assign do_pop    = pop && out_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push.n_results[RBUF_AW-1:0];
        rd_ptr_next = rd_ptr_reg + {{(RBUF_AW-1){1'b0}}, do_pop};
        count_next  = count_reg + {{(RBUF_AW-1){1'b0}}, push.n_results}
                    - {{RBUF_AW{1'b0}}, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.n_results != 2'd0) begin
            slot_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.n_results == 2'd2) begin
            slot_reg[wr_ptr_p1] <= push.res1;
        end
    end

endmodule

@@ rtl/measurement_schedule_record_filter_core.sv @@
// ----------------------------------------------------------------------------
// measurement_schedule_record_filter_core
// parses a measurement schedule list byte by byte and emits kept records
// ----------------------------------------------------------------------------
// path: a byte transaction passes the input register, then is parsed into the result
//   queue, whose head drives m_; a second result of the same byte follows it there
// throughput: one byte per cycle while the queue has room for two results; a byte
//   with two results puts both into the 4-entry result queue, which absorbs them
// reset: aresetn synchronous active low; clears parse state, queue and now_ms
// ----------------------------------------------------------------------------
module measurement_schedule_record_filter_core (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration: current time
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,

    // byte input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_start_of_list,

    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    output logic [15:0] m_setup_id,
    output logic [15:0] m_user_id,
    output logic [15:0] m_list_version,
    output logic [15:0] m_company_id,
    output logic [31:0] m_record_id,
    output logic [63:0] m_window_start,
    output logic [63:0] m_window_stop,
    output logic [5:0]  m_kept_count,
    output logic        m_last
);
    import msrf_pkg::*;

    // current time register; the user must write it only while the block is idle, the block does not enforce it
    logic [63:0] now_ms_reg;

    // input register stage
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_sol_reg;

    logic        room2;
    logic        proc;
    parse_out_t  po;
    result_t     head;

    // a held byte is parsed once the queue can take two results; the
    // queue check does not look at m_ready, so s_ready has no path from m_
    assign proc    = in_valid_reg && room2;
    assign s_ready = !in_valid_reg || proc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_ms_reg <= '0;
        end else if (cfg_wr_en) begin
            now_ms_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // payload of the input stage, loaded on each transaction
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_sol_reg  <= s_start_of_list;
        end
    end

    // header/record assembly and window filter
    msrf_parse u_parse (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (proc),
        .data_byte     (in_byte_reg),
        .start_of_list (in_sol_reg),
        .now_ms        (now_ms_reg),
        .po            (po)
    );

    // result queue decoupling the two sides
    msrf_rbuf u_rbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (po),
        .pop       (m_ready),
        .room2     (room2),
        .out_valid (m_valid),
        .out_data  (head)
    );

    // output fields straight from the queue head
    assign m_event_res    = head.event_res;
    assign m_setup_id     = head.setup_id;
    assign m_user_id      = head.user_id;
    assign m_list_version = head.list_version;
    assign m_company_id   = head.company_id;
    assign m_record_id    = head.record_id;
    assign m_window_start = head.window_start;
    assign m_window_stop  = head.window_stop;
    assign m_kept_count   = head.kept_count;
    assign m_last         = head.last;

endmodule
